### rtl/chassis_frame_receiver_assert.svh
// Assertion macros for the chassis frame receiver.
// Used by the top level only; the including module provides clk_i and rst_ni.
`ifndef CHASSIS_FRAME_RECEIVER_ASSERT_SVH
`define CHASSIS_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfr assertion failed");

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfr assertion failed");

`endif

### rtl/cfr_pkg.sv
// Package for the chassis frame receiver: frame constants, parser states,
// status codes, the result record and the wheel delta function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  // Frame header bytes.
  localparam logic [7:0] HdrFirst  = 8'h55;
  localparam logic [7:0] HdrSecond = 8'hAA;

  // Message type bytes.
  localparam logic [7:0] TypeSpeed   = 8'h01;
  localparam logic [7:0] TypeBattery = 8'h02;
  localparam logic [7:0] TypeCurrent = 8'h07;
  localparam logic [7:0] TypeVoltage = 8'h08;
  localparam logic [7:0] TypeFault   = 8'hFF;

  // Number of payload bytes kept after the type byte, and the position cap.
  localparam int unsigned DataBytes = 4;
  localparam logic [2:0]  PosCap    = 3'd5;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_LEN     = 3'd2,
    PH_SEQ     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } cfr_phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_SPEED   = 3'd0,
    ST_BATTERY = 3'd1,
    ST_CURRENT = 3'd2,
    ST_VOLTAGE = 3'd3,
    ST_FAULT   = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_CHK_ERR = 3'd6
  } cfr_status_e;

  // One result item.
  typedef struct packed {
    cfr_status_e        status;
    logic [7:0]         frame_seq;
    logic [15:0]        word_first;
    logic [15:0]        word_second;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } cfr_result_t;

  // Step request from the input stage to the parser.
  typedef struct packed {
    logic       step;
    logic [7:0] rx_byte;
  } cfr_step_t;

  // Signed count change with wrap at modulus 65535. A change of at most
  // half the modulus is taken as is, otherwise it is folded toward zero.
  function automatic logic [15:0] wheel_delta(input logic [15:0] old_count,
                                              input logic [15:0] new_count);
    logic [15:0] up;
    logic [15:0] down;
    logic [15:0] res;
    up   = new_count - old_count;
    down = old_count - new_count;
    if (new_count > old_count) begin
      // d - 65535 equals d + 1 modulo 2^16.
      res = up[15] ? (up + 16'd1) : up;
    end else begin
      // 65535 - d is the bitwise complement of d.
      res = down[15] ? ~down : (16'd0 - down);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/chassis_frame_receiver.sv
// Channel   | Dir | tdata (low bit up)                                       | tuser
// s_axis    | in  | rx_byte[7:0]                                             | -
// m_axis    | out | frame_seq, word_first, word_second, left_delta, right_delta | status[2:0]
//
// One byte is accepted every cycle while s_axis_tready is high. A byte is held
// in the input register, then the parser steps on it and the check byte's result is
// loaded into the result register.
// Reset clears the parser to header hunting with zero wheel counts.
// A stalled result holds the result register, and the input register then
// holds at most one more byte before s_axis_tready drops.
// Top level of the chassis frame receiver; uses cfr_pkg, cfr_in_reg,
// cfr_parser, cfr_out_reg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "chassis_frame_receiver_assert.svh"

module chassis_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [7:0] frame_seq, [23:8] word_first,
                                           // [39:24] word_second, [55:40] left_delta,
                                           // [71:56] right_delta
  output logic [2:0]       m_axis_tuser    // [2:0] status
);
  import cfr_pkg::*;

  cfr_step_t   step;
  logic        can_load;
  logic        res_valid;
  cfr_result_t res_new;
  cfr_result_t res_out;

  // Input register.
  cfr_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .advance_i       (can_load),
    .step_o          (step)
  );

  // Frame parser.
  cfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  // Result register.
  cfr_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (res_valid),
    .res_i           (res_new),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .res_o           (res_out)
  );

  // Pack the result onto the output stream.
  assign m_axis_tuser = res_out.status;
  assign m_axis_tdata = {res_out.right_delta, res_out.left_delta, res_out.word_second,
                         res_out.word_first, res_out.frame_seq};

  // Deltas are only reported for speed frames.
  `CFR_ASSERT_NOW(a_delta_speed_only, m_axis_tvalid && (m_axis_tuser != ST_SPEED), m_axis_tdata[71:40] == 32'd0)
  // A checksum error carries no words and no deltas.
  `CFR_ASSERT_NOW(a_chk_err_clear, m_axis_tvalid && (m_axis_tuser == ST_CHK_ERR), m_axis_tdata[71:8] == 64'd0)
  // With the result register stalled, the input side does not take a request
  // in a cycle in which the parser steps on a byte from the input register.
  `CFR_ASSERT_NOW(a_backpressure, m_axis_tvalid && !m_axis_tready && !can_load, !s_axis_tready || !step.step)
  // No result appears without a byte having been processed.
  `CFR_ASSERT_NEXT(a_no_phantom, !step.step && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid)

endmodule

`default_nettype wire

### rtl/cfr_in_reg.sv
// Input register of the chassis frame receiver: holds one accepted byte.
// Depends on cfr_pkg for the step record.
`timescale 1ns / 1ps
`default_nettype none

module cfr_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic             advance_i,
  output cfr_pkg::cfr_step_t    step_o
);
  import cfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // The register takes a new byte when empty or when its byte moves on.
  assign s_axis_tready_o = !valid_q || advance_i;
  assign valid_d         = s_axis_tready_o ? s_axis_tvalid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload byte needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  // The held byte is processed in the cycle it may advance.
  assign step_o.step    = valid_q && advance_i;
  assign step_o.rx_byte = byte_q;

endmodule

`default_nettype wire

### rtl/cfr_parser.sv
// Frame parser of the chassis frame receiver: phase, running XOR, payload
// capture and stored wheel counts; builds a result on the check byte. Uses cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfr_pkg::cfr_step_t   step_i,
  output logic                      res_valid_o,
  output cfr_pkg::cfr_result_t      res_o
);
  import cfr_pkg::*;

  cfr_phase_e  phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  data_q [DataBytes];
  logic [7:0]  data_d [DataBytes];
  logic [15:0] last_l_q, last_l_d;
  logic [15:0] last_r_q, last_r_d;
  logic [2:0]  pos_q, pos_d;

  logic [7:0]  b;
  logic [1:0]  data_idx;
  logic [15:0] w1, w2;
  logic        sum_ok;

  assign b        = step_i.rx_byte;
  assign data_idx = 2'(pos_q - 3'd1);
  assign w1       = {data_q[0], data_q[1]};
  assign w2       = {data_q[2], data_q[3]};
  assign sum_ok   = (b == xor_q);

  // Next state and result for one byte.
  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    left_d   = left_q;
    seq_d    = seq_q;
    type_d   = type_q;
    data_d   = data_q;
    last_l_d = last_l_q;
    last_r_d = last_r_q;
    pos_d    = pos_q;

    res_valid_o       = 1'b0;
    res_o.status      = ST_CHK_ERR;
    res_o.frame_seq   = seq_q;
    res_o.word_first  = 16'd0;
    res_o.word_second = 16'd0;
    res_o.left_delta  = 16'sd0;
    res_o.right_delta = 16'sd0;

    // Classification of a frame whose check byte matches.
    if (sum_ok) begin
      res_o.word_first  = w1;
      res_o.word_second = w2;
      unique case (type_q)
        TypeSpeed: begin
          res_o.status      = ST_SPEED;
          res_o.left_delta  = $signed(wheel_delta(last_l_q, w1));
          res_o.right_delta = $signed(wheel_delta(last_r_q, w2));
        end
        TypeBattery: res_o.status = ST_BATTERY;
        TypeCurrent: res_o.status = ST_CURRENT;
        TypeVoltage: res_o.status = ST_VOLTAGE;
        TypeFault:   res_o.status = ST_FAULT;
        default:     res_o.status = ST_UNKNOWN;
      endcase
    end

    if (step_i.step) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == HdrFirst) begin
            xor_d   = b;
            phase_d = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (b == HdrSecond) begin
            xor_d   = xor_q ^ b;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          left_d  = b;
          xor_d   = xor_q ^ b;
          type_d  = 8'd0;
          pos_d   = 3'd0;
          phase_d = PH_SEQ;
          for (int i = 0; i < DataBytes; i++) begin
            data_d[i] = 8'd0;
          end
        end
        PH_SEQ: begin
          seq_d   = b;
          xor_d   = xor_q ^ b;
          phase_d = (left_q != 8'd0) ? PH_PAYLOAD : PH_CHECK;
        end
        PH_PAYLOAD: begin
          xor_d = xor_q ^ b;
          // First payload byte is the type, the next four are kept.
          if (pos_q == 3'd0) begin
            type_d = b;
          end else if (pos_q <= 3'd4) begin
            data_d[data_idx] = b;
          end
          if (pos_q < PosCap) begin
            pos_d = pos_q + 3'd1;
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d     = PH_HUNT;
          res_valid_o = 1'b1;
          if (sum_ok && (type_q == TypeSpeed)) begin
            last_l_d = w1;
            last_r_d = w2;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      xor_q    <= 8'd0;
      left_q   <= 8'd0;
      seq_q    <= 8'd0;
      type_q   <= 8'd0;
      last_l_q <= 16'd0;
      last_r_q <= 16'd0;
      pos_q    <= 3'd0;
      for (int i = 0; i < DataBytes; i++) begin
        data_q[i] <= 8'd0;
      end
    end else begin
      phase_q  <= phase_d;
      xor_q    <= xor_d;
      left_q   <= left_d;
      seq_q    <= seq_d;
      type_q   <= type_d;
      last_l_q <= last_l_d;
      last_r_q <= last_r_d;
      pos_q    <= pos_d;
      data_q   <= data_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cfr_out_reg.sv
// Result register of the chassis frame receiver: holds one result until the
// downstream side takes it. Depends on cfr_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module cfr_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire cfr_pkg::cfr_result_t  res_i,
  output logic                       can_load_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output cfr_pkg::cfr_result_t       res_o
);
  import cfr_pkg::*;

  logic        valid_q, valid_d;
  cfr_result_t res_q;

  // Free when empty or when the held result is taken this cycle.
  assign can_load_o = !valid_q || m_axis_tready_i;
  assign valid_d    = can_load_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign res_o           = res_q;

endmodule

`default_nettype wire
